>>> hdl/mnsc_pkg.sv
// Shared types and constants for the metric name syntax checker.
`timescale 1ns / 1ps

package mnsc_pkg;

  localparam int unsigned LEN_W = 10;
  localparam int unsigned CNT_W = 11;

  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(255);

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_INVALID  = 2'd3
  } status_t;

endpackage

>>> hdl/metric_name_syntax_checker.sv
// Top level: streaming checker of dotted metric names, one byte per transfer.
//
// Usage:
//   Input channel in_*: one transfer per name byte. in_tdata holds the byte,
//   in_tuser[0] says the byte is present (0 = marker transfer with no byte),
//   in_tlast marks the last transfer of a name and triggers a status.
//   Result channel out_*: one transfer per name, out_tdata[1:0] is the status
//   (0 ok, 1 empty, 2 too long, 3 invalid syntax), bits above are zero.
//   cfg_we / cfg_wdata load the longest accepted name length (bytes); write
//   only while no name is in flight.
// Timing:
//   Transfers land in an input register, one pass of flag/counter logic runs,
//   and the status lands in the output register when the in_tlast transfer
//   leaves the input register. Throughput is one transfer per cycle while
//   in_tready stays high.
//   in_tready drops only while the input register holds a last transfer and
//   the output register still holds an untaken status; other bytes keep
//   flowing during an output stall.
// Reset:
//   Synchronous active-low rst_n empties both registers, clears the name
//   state and sets the maximum length to 255.
`timescale 1ns / 1ps

module metric_name_syntax_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] char_byte
  input  logic [0:0]                in_tuser,   // [0] has_byte
  input  logic                      in_tlast,   // end_of_name
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,  // [1:0] status, [7:2] zero
  input  logic                      cfg_we,
  input  logic [mnsc_pkg::LEN_W-1:0] cfg_wdata
);
  import mnsc_pkg::*;

  // input register
  logic            s1_valid_r;
  logic [7:0]      s1_byte_r;
  logic            s1_has_r;
  logic            s1_last_r;

  // name state
  logic [CNT_W-1:0] byte_cnt_r,  byte_cnt_nxt;
  logic             seg_start_r, seg_start_nxt;
  logic             snake_r,     snake_nxt;
  logic             snake_need_r, snake_need_nxt;
  logic             camel_r,     camel_nxt;
  logic             camel_need_r, camel_need_nxt;
  logic             bad_r,       bad_nxt;

  logic [LEN_W-1:0] max_len_r;

  // output register
  logic             out_valid_r;
  status_t          out_status_r;

  logic    out_free, advance, in_fire;
  logic    is_lower, is_upper, is_digit;
  logic    seg_good_now, seg_good_nxt;
  status_t status_nxt;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign is_lower = (s1_byte_r >= 8'h61) && (s1_byte_r <= 8'h7A);
  assign is_upper = (s1_byte_r >= 8'h41) && (s1_byte_r <= 8'h5A);
  assign is_digit = (s1_byte_r >= 8'h30) && (s1_byte_r <= 8'h39);

  assign seg_good_now = !seg_start_r &&
                        ((snake_r && !snake_need_r) || (camel_r && !camel_need_r));

  always_comb begin
    byte_cnt_nxt   = byte_cnt_r;
    seg_start_nxt  = seg_start_r;
    snake_nxt      = snake_r;
    snake_need_nxt = snake_need_r;
    camel_nxt      = camel_r;
    camel_need_nxt = camel_need_r;
    bad_nxt        = bad_r;
    if (s1_has_r) begin
      if (byte_cnt_r != CNT_MAX) begin
        byte_cnt_nxt = byte_cnt_r + CNT_W'(1);
      end
      if (s1_byte_r == CH_DOT) begin
        if (!seg_good_now) begin
          bad_nxt = 1'b1;
        end
        seg_start_nxt  = 1'b1;
        snake_nxt      = 1'b0;
        camel_nxt      = 1'b0;
        snake_need_nxt = 1'b0;
        camel_need_nxt = 1'b0;
      end else if (seg_start_r) begin
        // segment must open with a lowercase letter
        seg_start_nxt  = 1'b0;
        snake_need_nxt = 1'b0;
        camel_need_nxt = 1'b0;
        snake_nxt      = is_lower;
        camel_nxt      = is_lower;
        if (!is_lower) begin
          bad_nxt = 1'b1;
        end
      end else begin
        if (snake_r) begin
          if (is_lower || is_digit) begin
            snake_need_nxt = 1'b0;
          end else if ((s1_byte_r == CH_UNDER || s1_byte_r == CH_DASH) && !snake_need_r) begin
            snake_need_nxt = 1'b1;
          end else begin
            snake_nxt = 1'b0;
          end
        end
        if (camel_r) begin
          if (is_lower || is_upper || is_digit) begin
            camel_need_nxt = 1'b0;
          end else if (s1_byte_r == CH_DASH && !camel_need_r) begin
            camel_need_nxt = 1'b1;
          end else begin
            camel_nxt = 1'b0;
          end
        end
        if (!snake_nxt && !camel_nxt) begin
          bad_nxt = 1'b1;
        end
      end
    end
  end

  assign seg_good_nxt = !seg_start_nxt &&
                        ((snake_nxt && !snake_need_nxt) || (camel_nxt && !camel_need_nxt));

  always_comb begin
    if (byte_cnt_nxt == '0) begin
      status_nxt = ST_EMPTY;
    end else if (byte_cnt_nxt > {1'b0, max_len_r}) begin
      status_nxt = ST_TOO_LONG;
    end else if (bad_nxt || !seg_good_nxt) begin
      status_nxt = ST_INVALID;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_has_r  <= in_tuser[0];
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (advance && s1_last_r)) begin
      byte_cnt_r   <= '0;
      seg_start_r  <= 1'b1;
      snake_r      <= 1'b0;
      snake_need_r <= 1'b0;
      camel_r      <= 1'b0;
      camel_need_r <= 1'b0;
      bad_r        <= 1'b0;
    end else if (advance) begin
      byte_cnt_r   <= byte_cnt_nxt;
      seg_start_r  <= seg_start_nxt;
      snake_r      <= snake_nxt;
      snake_need_r <= snake_need_nxt;
      camel_r      <= camel_nxt;
      camel_need_r <= camel_need_nxt;
      bad_r        <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= LEN_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      out_status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_status_r};

`ifndef SYNTHESIS
  // input stalls only behind a finished name whose status cannot be placed
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_tready))
    else $error("in_tready low without a blocked result");

  // name state starts over after every status
  a_name_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_last_r) |=> (byte_cnt_r == '0 && seg_start_r && !bad_r))
    else $error("name state not cleared after a status");

  // a status is only produced by a last transfer
  a_status_src: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r ##1 out_valid_r) |-> $past(advance && s1_last_r))
    else $error("status appeared without a last transfer");

  // the count only moves on a present byte
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !s1_last_r && !s1_has_r) |=> $stable(byte_cnt_r))
    else $error("byte count moved on a marker transfer");
`endif

endmodule

>>> tb/sv/metric_name_syntax_checker_tb.sv
// Self-checking testbench for the metric name syntax checker.
`timescale 1ns / 1ps

module metric_name_syntax_checker_tb;
  import mnsc_pkg::*;

  localparam int     CLK_HALF_NS  = 5;
  localparam int     RESET_CYCLES = 12;
  localparam int     HOLD_CYCLES  = 250;
  localparam int     DRAIN_CYCLES = 8;
  localparam int     PHASE_ITEMS  = 96;
  localparam longint TIMEOUT_NS   = 2_000_000;

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       last;
    logic       pinned;  // want is typed in, not predicted
    status_t    want;
  } script_row_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = 8'h00;  // [7:0] char_byte
  logic [0:0]       in_tuser   = 1'b0;   // [0] has_byte
  logic             in_tlast   = 1'b0;   // end_of_name
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [7:0]       out_tdata;           // [1:0] status, [7:2] zero
  logic             cfg_we     = 1'b0;
  logic [LEN_W-1:0] cfg_wdata  = '0;

  metric_name_syntax_checker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // name tracking state, mirrors the block
  logic [CNT_W-1:0] name_len;
  logic [LEN_W-1:0] len_limit;
  logic             in_seg_head;
  logic             snake_ok;
  logic             snake_pend;
  logic             camel_ok;
  logic             camel_pend;
  logic             name_bad;

  status_t    status_q[$];
  status_t    head_status;
  logic [7:0] name_buf[$];
  int         errors;
  int         items_sent;
  int         sender_idle_pct;
  int         sink_stall_pct;
  bit         hold_req;

  script_row_t name_script [25] = '{
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b1, 1'b1, ST_EMPTY},
    '{"a",   1'b1, 1'b1, 1'b1, ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b1, 1'b1, ST_EMPTY},
    '{"A",   1'b1, 1'b1, 1'b1, ST_INVALID},
    '{".",   1'b1, 1'b1, 1'b1, ST_INVALID},
    '{"a",   1'b1, 1'b0, 1'b0, ST_OK},
    '{".",   1'b1, 1'b0, 1'b0, ST_OK},
    '{"b",   1'b1, 1'b0, 1'b0, ST_OK},
    '{8'h00, 1'b0, 1'b1, 1'b0, ST_OK},
    '{"a",   1'b1, 1'b0, 1'b0, ST_OK},
    '{"_",   1'b1, 1'b0, 1'b0, ST_OK},
    '{"B",   1'b1, 1'b1, 1'b0, ST_OK},
    '{"a",   1'b1, 1'b0, 1'b0, ST_OK},
    '{"B",   1'b1, 1'b0, 1'b0, ST_OK},
    '{"-",   1'b1, 1'b0, 1'b0, ST_OK},
    '{"c",   1'b1, 1'b1, 1'b0, ST_OK},
    '{"a",   1'b1, 1'b0, 1'b0, ST_OK},
    '{"-",   1'b1, 1'b1, 1'b0, ST_OK},
    '{"a",   1'b1, 1'b0, 1'b0, ST_OK},
    '{".",   1'b1, 1'b0, 1'b0, ST_OK},
    '{".",   1'b1, 1'b1, 1'b1, ST_INVALID},
    '{"a",   1'b1, 1'b0, 1'b0, ST_OK},
    '{8'h0A, 1'b1, 1'b1, 1'b1, ST_INVALID}
  };

  function automatic void clear_name();
    name_len    = '0;
    in_seg_head = 1'b1;
    snake_ok    = 1'b0;
    snake_pend  = 1'b0;
    camel_ok    = 1'b0;
    camel_pend  = 1'b0;
    name_bad    = 1'b0;
  endfunction

  function automatic logic seg_complete();
    return !in_seg_head && ((snake_ok && !snake_pend) || (camel_ok && !camel_pend));
  endfunction

  function automatic void absorb_char(input logic [7:0] c);
    logic lower, upper, digit;
    lower = (c >= "a") && (c <= "z");
    upper = (c >= "A") && (c <= "Z");
    digit = (c >= "0") && (c <= "9");
    if (name_len != CNT_MAX) name_len++;
    if (c == CH_DOT) begin
      if (!seg_complete()) name_bad = 1'b1;
      in_seg_head = 1'b1;
      snake_ok    = 1'b0;
      camel_ok    = 1'b0;
      snake_pend  = 1'b0;
      camel_pend  = 1'b0;
    end else if (in_seg_head) begin
      in_seg_head = 1'b0;
      snake_pend  = 1'b0;
      camel_pend  = 1'b0;
      snake_ok    = lower;
      camel_ok    = lower;
      if (!lower) name_bad = 1'b1;
    end else begin
      if (snake_ok) begin
        if (lower || digit) snake_pend = 1'b0;
        else if ((c == CH_UNDER || c == CH_DASH) && !snake_pend) snake_pend = 1'b1;
        else snake_ok = 1'b0;
      end
      if (camel_ok) begin
        if (lower || upper || digit) camel_pend = 1'b0;
        else if (c == CH_DASH && !camel_pend) camel_pend = 1'b1;
        else camel_ok = 1'b0;
      end
      if (!snake_ok && !camel_ok) name_bad = 1'b1;
    end
  endfunction

  function automatic status_t name_verdict();
    if (name_len == '0) return ST_EMPTY;
    if (name_len > CNT_W'(len_limit)) return ST_TOO_LONG;
    if (name_bad || !seg_complete()) return ST_INVALID;
    return ST_OK;
  endfunction

  function automatic logic [7:0] alnum_byte(input bit mixed_case);
    int r;
    r = $urandom_range(mixed_case ? 61 : 35);
    if (r < 26) return "a" + 8'(r);
    if (r < 36) return "0" + 8'(r - 26);
    return "A" + 8'(r - 36);
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(5))
      0: return CH_DOT;
      1: return CH_UNDER;
      2: return CH_DASH;
      3: return alnum_byte(1'b1);
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // One transfer on the input side; the predictor runs at the accepting edge.
  task automatic send_item(input logic [7:0] c, input logic has, input logic last,
                           input logic pinned = 1'b0, input status_t want = ST_OK);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= has;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (has) absorb_char(c);
    if (has || last) items_sent++;
    if (last) begin
      status_q.push_back(pinned ? want : name_verdict());
      clear_name();
    end
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic settle();
    go_quiet();
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LEN_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    len_limit  = v;
  endtask

  // n lowercase bytes, last one closes the name; zero length gives a bare end marker
  task automatic send_run(input int n);
    if (n == 0) send_item(8'($urandom), 1'b0, 1'b1);
    for (int i = 0; i < n; i++) send_item("a", 1'b1, i == n - 1);
  endtask

  task automatic probe_limit(input int v);
    settle();
    write_limit(LEN_W'(v));
    send_run(v);
    send_run(v + 1);
  endtask

  task automatic build_name();
    int segs;
    bit camel;
    name_buf.delete();
    case ($urandom_range(9))
      0: return;
      1, 2: begin
        repeat ($urandom_range(8, 1)) name_buf.push_back(noise_byte());
        return;
      end
      default: ;
    endcase
    segs = $urandom_range(3, 1);
    for (int s = 0; s < segs; s++) begin
      if (s > 0) name_buf.push_back(CH_DOT);
      camel = $urandom_range(1);
      name_buf.push_back("a" + 8'($urandom_range(25)));
      repeat ($urandom_range(6)) begin
        if ($urandom_range(3) == 0)
          name_buf.push_back((camel || $urandom_range(1)) ? CH_DASH : CH_UNDER);
        name_buf.push_back(alnum_byte(camel));
      end
    end
    // break one name in five
    if ($urandom_range(4) == 0) begin
      case ($urandom_range(3))
        0: name_buf[$urandom_range(name_buf.size() - 1)] = noise_byte();
        1: name_buf.push_back(CH_DASH);
        2: name_buf.push_back(CH_DOT);
        default: name_buf.insert($urandom_range(name_buf.size() - 1), CH_DOT);
      endcase
    end
  endtask

  task automatic send_name();
    bit tail_on_byte;
    build_name();
    tail_on_byte = $urandom_range(1);
    foreach (name_buf[i]) begin
      if ($urandom_range(24) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(name_buf[i], 1'b1, tail_on_byte && (i == name_buf.size() - 1));
    end
    if (!tail_on_byte || name_buf.size() == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input bit squeeze);
    int start;
    settle();
    write_limit(LEN_W'($urandom_range(24, 2)));
    sender_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
    hold_req        = squeeze;
    start           = items_sent;
    while (items_sent - start < PHASE_ITEMS) send_name();
  endtask

  initial begin
    forever #CLK_HALF_NS clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (status_q.size() == 0) begin
        flag_mismatch($sformatf("status %0d with no name pending", out_tdata));
      end else begin
        head_status = status_q.pop_front();
        if (out_tdata !== {6'b0, head_status})
          flag_mismatch($sformatf("out_tdata %0h, expected status %0d",
                                  out_tdata, head_status));
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    clear_name();
    len_limit       = LEN_RESET;
    errors          = 0;
    items_sent      = 0;
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    hold_req        = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    foreach (name_script[i])
      send_item(name_script[i].ch, name_script[i].has, name_script[i].last,
                name_script[i].pinned, name_script[i].want);

    // small limits probed at the limit and one past it; top limit with a long name
    probe_limit(0);
    probe_limit(1);
    settle();
    write_limit(LEN_W'(1023));
    send_run(40);

    run_phase(0, 0, 1'b1);
    run_phase(85, 0, 1'b0);
    run_phase(0, 85, 1'b0);
    run_phase(21, 21, 1'b0);
    settle();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/mnsc_pkg.sv
hdl/metric_name_syntax_checker.sv
tb/sv/metric_name_syntax_checker_tb.sv
